// File: rtl/vwb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vwb_pkg: shared types and constants of the volume blur
// Register map, controller states, the command and status bundles between
// controller and datapath, and fixed field widths.
// ----------------------------------------------------------------------------
package vwb_pkg;

	// default volume limits
	localparam int DEF_MAX_X = 64;
	localparam int DEF_MAX_Y = 64;
	localparam int DEF_MAX_Z = 64;

	// field widths
	localparam int SIZE_W    = 7;
	localparam int WGT_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int VOX_W     = 8;

	// arithmetic widths
	localparam int SUM_W   = 12;	// up to 12 voxels per class
	localparam int SSUM_W  = 13;	// class sum times its scale
	localparam int PROD_W  = 29;
	localparam int NUM_W   = 32;
	localparam int WSUM_W  = 18;
	localparam int DEN_W   = 23;
	localparam int DCNT_W  = 5;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X,
		REG_SIZE_Y,
		REG_SIZE_Z,
		REG_W_CENTER,
		REG_W_FACE,
		REG_W_EDGE,
		REG_W_CORNER
	} cfg_reg_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP1,
		ST_PREP2,
		ST_DECIDE,
		ST_RD,
		ST_AC,
		ST_MUL,
		ST_MAC,
		ST_DIVS,
		ST_DIV,
		ST_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic decide;
		logic win_rd;
		logic win_acc;
		logic mul;
		logic mac;
		logic div_init;
		logic div_step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit;
		logic win_last;
		logic mac_last;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// File: rtl/vwb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vwb_in_if: input request channel
// Valid/ready channel carrying one voxel or drain request.
// ----------------------------------------------------------------------------
interface vwb_in_if;
	import vwb_pkg::*;

	logic             valid;
	logic             ready;
	logic             func;
	logic [VOX_W-1:0] voxel_in;

	modport source (output valid, output func, output voxel_in, input ready);
	modport sink   (input valid, input func, input voxel_in, output ready);
endinterface
`default_nettype wire

// File: rtl/vwb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vwb_out_if: output request channel
// Valid/ready channel carrying one blurred voxel.
// ----------------------------------------------------------------------------
interface vwb_out_if;
	import vwb_pkg::*;

	logic             valid;
	logic             ready;
	logic [VOX_W-1:0] voxel_out;
	logic             last;

	modport source (output valid, output voxel_out, output last, input ready);
	modport sink   (input valid, input voxel_out, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/vwb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vwb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vwb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/vwb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vwb_ctrl: sequencer of the volume blur
// Walks one request through position update and, if it makes a result,
// a 27-tap window read, weighting, division and result hand-off.
// ----------------------------------------------------------------------------
module vwb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  vwb_pkg::stat_t stat,
	output vwb_pkg::cmd_t  cmd
);
	import vwb_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_PREP1;
				end
			end
			ST_PREP1: state_d = ST_PREP2;
			ST_PREP2: state_d = ST_DECIDE;
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = stat.emit ? ST_RD : ST_IDLE;
			end
			ST_RD: begin
				cmd.win_rd = 1'b1;
				state_d    = ST_AC;
			end
			ST_AC: begin
				cmd.win_acc = 1'b1;
				state_d     = stat.win_last ? ST_MUL : ST_RD;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_MAC;
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
				state_d = stat.mac_last ? ST_DIVS : ST_MUL;
			end
			ST_DIVS: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/vwb_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vwb_dp: datapath of the volume blur
// Config registers, stream positions, voxel ring buffer, class sums,
// weight multiply-accumulate, restoring divider and output register.
// ----------------------------------------------------------------------------
module vwb_dp #(
	parameter int MAX_X = vwb_pkg::DEF_MAX_X,
	parameter int MAX_Y = vwb_pkg::DEF_MAX_Y,
	parameter int MAX_Z = vwb_pkg::DEF_MAX_Z
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vwb_pkg::cmd_t                   cmd,
	output vwb_pkg::stat_t                  stat,
	input  logic                            cfg_we,
	input  logic [vwb_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [vwb_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_func,
	input  logic [vwb_pkg::VOX_W-1:0]       in_voxel,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [vwb_pkg::VOX_W-1:0]       out_voxel,
	output logic                            out_last
);
	import vwb_pkg::*;

	localparam int CX_W     = $clog2(MAX_X + 1);
	localparam int CY_W     = $clog2(MAX_Y + 1);
	localparam int CZ_W     = $clog2(MAX_Z + 1);
	localparam int SXY_W    = $clog2(MAX_X * MAX_Y + 1);
	localparam int POS_W    = $clog2(MAX_X * MAX_Y * MAX_Z + 1);
	localparam int RING_LEN = 2 * MAX_X * MAX_Y + 2 * MAX_X + 4;
	localparam int RA_W     = $clog2(RING_LEN);
	localparam int SA_W     = RA_W + 2;
	localparam int CMP_W    = 12;

	// configuration registers
	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [WGT_W-1:0]  w_center_q, w_face_q, w_edge_q, w_corner_q;
	logic              size_wr;

	assign size_wr = cfg_we && (cfg_idx == REG_SIZE_X || cfg_idx == REG_SIZE_Y ||
		cfg_idx == REG_SIZE_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q   <= SIZE_W'(64);
			size_y_q   <= SIZE_W'(64);
			size_z_q   <= SIZE_W'(64);
			w_center_q <= WGT_W'(256);
			w_face_q   <= WGT_W'(256);
			w_edge_q   <= WGT_W'(256);
			w_corner_q <= WGT_W'(256);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SIZE_X:   size_x_q   <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Y:   size_y_q   <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Z:   size_z_q   <= cfg_data[SIZE_W-1:0];
				REG_W_CENTER: w_center_q <= cfg_data[WGT_W-1:0];
				REG_W_FACE:   w_face_q   <= cfg_data[WGT_W-1:0];
				REG_W_EDGE:   w_edge_q   <= cfg_data[WGT_W-1:0];
				REG_W_CORNER: w_corner_q <= cfg_data[WGT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp extents to [3, MAX]
	logic [CX_W-1:0] sx;
	logic [CY_W-1:0] sy;
	logic [CZ_W-1:0] sz;

	always_comb begin
		if (CMP_W'(size_x_q) < CMP_W'(3))          sx = CX_W'(3);
		else if (CMP_W'(size_x_q) > CMP_W'(MAX_X)) sx = CX_W'(MAX_X);
		else                                       sx = CX_W'(size_x_q);
		if (CMP_W'(size_y_q) < CMP_W'(3))          sy = CY_W'(3);
		else if (CMP_W'(size_y_q) > CMP_W'(MAX_Y)) sy = CY_W'(MAX_Y);
		else                                       sy = CY_W'(size_y_q);
		if (CMP_W'(size_z_q) < CMP_W'(3))          sz = CZ_W'(3);
		else if (CMP_W'(size_z_q) > CMP_W'(MAX_Z)) sz = CZ_W'(MAX_Z);
		else                                       sz = CZ_W'(size_z_q);
	end

	// derived extents, one multiply per stage
	logic [SXY_W-1:0] sxsy_q;
	logic [POS_W-1:0] total_q, delay_q;

	always_ff @(posedge clk) begin
		sxsy_q  <= SXY_W'(sx) * SXY_W'(sy);
		total_q <= POS_W'(sxsy_q) * POS_W'(sz);
		delay_q <= POS_W'(sxsy_q) + POS_W'(sx) + POS_W'(1);
	end

	// request latch
	logic             func_q;
	logic [VOX_W-1:0] vox_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= in_func;
			vox_q  <= in_voxel;
		end
	end

	// stream positions
	logic [POS_W-1:0] in_pos_q, out_pos_q, in_eff;
	logic [RA_W-1:0]  in_ring_q, out_ring_q, in_ring_eff;
	logic [CX_W-1:0]  ox_q;
	logic [CY_W-1:0]  oy_q;
	logic [CZ_W-1:0]  oz_q;
	logic             full, vol_done;

	assign full        = in_pos_q >= total_q;
	assign in_eff      = full ? '0 : in_pos_q;
	assign in_ring_eff = full ? '0 : in_ring_q;
	assign vol_done    = (out_pos_q + POS_W'(1)) >= total_q;
	assign stat.emit   = func_q ? (full && out_pos_q < total_q) : (in_eff >= delay_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q   <= '0;
			out_pos_q  <= '0;
			in_ring_q  <= '0;
			out_ring_q <= '0;
			ox_q       <= '0;
			oy_q       <= '0;
			oz_q       <= '0;
		end else if (size_wr || (cmd.finish && vol_done)) begin
			in_pos_q   <= '0;
			out_pos_q  <= '0;
			in_ring_q  <= '0;
			out_ring_q <= '0;
			ox_q       <= '0;
			oy_q       <= '0;
			oz_q       <= '0;
		end else if (cmd.decide && !func_q) begin
			in_pos_q  <= in_eff + POS_W'(1);
			in_ring_q <= (in_ring_eff == RA_W'(RING_LEN - 1)) ? '0 : in_ring_eff + RA_W'(1);
			if (full) begin
				out_pos_q  <= '0;
				out_ring_q <= '0;
				ox_q       <= '0;
				oy_q       <= '0;
				oz_q       <= '0;
			end
		end else if (cmd.finish) begin
			out_pos_q  <= out_pos_q + POS_W'(1);
			out_ring_q <= (out_ring_q == RA_W'(RING_LEN - 1)) ? '0 : out_ring_q + RA_W'(1);
			if (ox_q == sx - CX_W'(1)) begin
				ox_q <= '0;
				if (oy_q == sy - CY_W'(1)) begin
					oy_q <= '0;
					oz_q <= oz_q + CZ_W'(1);
				end else begin
					oy_q <= oy_q + CY_W'(1);
				end
			end else begin
				ox_q <= ox_q + CX_W'(1);
			end
		end
	end

	// window walk: tap index 0..2 per axis stands for offset -1..+1
	logic [1:0] wx_q, wy_q, wz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wx_q <= '0;
			wy_q <= '0;
			wz_q <= '0;
		end else if (cmd.decide) begin
			wx_q <= '0;
			wy_q <= '0;
			wz_q <= '0;
		end else if (cmd.win_acc) begin
			if (wx_q == 2'd2) begin
				wx_q <= '0;
				if (wy_q == 2'd2) begin
					wy_q <= '0;
					wz_q <= wz_q + 2'd1;
				end else begin
					wy_q <= wy_q + 2'd1;
				end
			end else begin
				wx_q <= wx_q + 2'd1;
			end
		end
	end

	assign stat.win_last = (wx_q == 2'd2) && (wy_q == 2'd2) && (wz_q == 2'd2);

	// ring address of the tap
	logic signed [SA_W-1:0] tz, ty, tx, ta, ring_s;
	logic [RA_W-1:0]        raddr;

	assign ring_s = $signed(SA_W'(RING_LEN));

	always_comb begin
		case (wz_q)
			2'd0:    tz = -$signed(SA_W'(sxsy_q));
			2'd2:    tz = $signed(SA_W'(sxsy_q));
			default: tz = '0;
		endcase
		case (wy_q)
			2'd0:    ty = -$signed(SA_W'(sx));
			2'd2:    ty = $signed(SA_W'(sx));
			default: ty = '0;
		endcase
		case (wx_q)
			2'd0:    tx = -$signed(SA_W'(1));
			2'd2:    tx = $signed(SA_W'(1));
			default: tx = '0;
		endcase
		ta = $signed(SA_W'(out_ring_q)) + tz + ty + tx;
		if (ta < 0)            raddr = RA_W'(ta + ring_s);
		else if (ta >= ring_s) raddr = RA_W'(ta - ring_s);
		else                   raddr = RA_W'(ta);
	end

	// interior test of the source voxel (coordinate plus one)
	logic [CX_W:0] qx1;
	logic [CY_W:0] qy1;
	logic [CZ_W:0] qz1;
	logic          interior;
	logic [1:0]    cls;

	assign qx1 = (CX_W + 1)'(ox_q) + (CX_W + 1)'(wx_q);
	assign qy1 = (CY_W + 1)'(oy_q) + (CY_W + 1)'(wy_q);
	assign qz1 = (CZ_W + 1)'(oz_q) + (CZ_W + 1)'(wz_q);
	assign interior = qx1 >= (CX_W + 1)'(2) && qx1 <= (CX_W + 1)'(sx) - (CX_W + 1)'(1) &&
		qy1 >= (CY_W + 1)'(2) && qy1 <= (CY_W + 1)'(sy) - (CY_W + 1)'(1) &&
		qz1 >= (CZ_W + 1)'(2) && qz1 <= (CZ_W + 1)'(sz) - (CZ_W + 1)'(1);
	assign cls = 2'(wx_q != 2'd1) + 2'(wy_q != 2'd1) + 2'(wz_q != 2'd1);

	// voxel ring
	logic [VOX_W-1:0] rdata;

	vwb_ram #(
		.WIDTH (VOX_W),
		.DEPTH (RING_LEN)
	) u_ring (
		.clk   (clk),
		.we    (cmd.decide && !func_q),
		.waddr (in_ring_eff),
		.wdata (vox_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// tap stage
	logic       rd_vld_s1;
	logic [1:0] cls_s1;

	always_ff @(posedge clk) begin
		if (cmd.win_rd) begin
			rd_vld_s1 <= interior;
			cls_s1    <= cls;
		end
	end

	// class sums
	logic [SUM_W-1:0] sum_c_q, sum_f_q, sum_e_q, sum_k_q;

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			sum_c_q <= '0;
			sum_f_q <= '0;
			sum_e_q <= '0;
			sum_k_q <= '0;
		end else if (cmd.win_acc && rd_vld_s1) begin
			case (cls_s1)
				2'd0:    sum_c_q <= sum_c_q + SUM_W'(rdata);
				2'd1:    sum_f_q <= sum_f_q + SUM_W'(rdata);
				2'd2:    sum_e_q <= sum_e_q + SUM_W'(rdata);
				default: sum_k_q <= sum_k_q + SUM_W'(rdata);
			endcase
		end
	end

	// weighted numerator: one term per multiply step
	logic [1:0]        k_q;
	logic [SSUM_W-1:0] ssum;
	logic [WGT_W-1:0]  wsel;
	logic [PROD_W-1:0] prod_q;
	logic [NUM_W-1:0]  num_q;

	always_comb begin
		case (k_q)
			2'd0: begin
				ssum = (SSUM_W'(sum_c_q) << 4) + (SSUM_W'(sum_c_q) << 3);
				wsel = w_center_q;
			end
			2'd1: begin
				ssum = SSUM_W'(sum_f_q) << 2;
				wsel = w_face_q;
			end
			2'd2: begin
				ssum = SSUM_W'(sum_e_q) << 1;
				wsel = w_edge_q;
			end
			default: begin
				ssum = (SSUM_W'(sum_k_q) << 1) + SSUM_W'(sum_k_q);
				wsel = w_corner_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.decide) begin
			k_q <= '0;
		end else if (cmd.mac) begin
			k_q <= k_q + 2'd1;
		end
	end

	assign stat.mac_last = (k_q == 2'd3);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PROD_W'(wsel) * PROD_W'(ssum);
		end
		if (cmd.decide) begin
			num_q <= '0;
		end else if (cmd.mac) begin
			num_q <= num_q + NUM_W'(prod_q);
		end
	end

	// restoring divider, one quotient bit per cycle
	logic [WSUM_W-1:0] wsum;
	logic [DEN_W-1:0]  den_q, rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W:0]    trial;
	logic [DCNT_W-1:0] dcnt_q;
	logic              take;

	assign wsum  = WSUM_W'(w_center_q) + WSUM_W'(w_face_q) + WSUM_W'(w_edge_q) +
		WSUM_W'(w_corner_q);
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_init) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	assign stat.div_last = (dcnt_q == DCNT_W'(NUM_W - 1));

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			den_q <= (DEN_W'(wsum) << 4) + (DEN_W'(wsum) << 3);
			rem_q <= '0;
			quo_q <= num_q;
		end else if (cmd.div_step) begin
			rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	// output register
	logic [VOX_W-1:0] res;

	always_comb begin
		if (den_q == '0)               res = '0;
		else if (|quo_q[NUM_W-1:VOX_W]) res = '1;
		else                           res = quo_q[VOX_W-1:0];
	end

	assign stat.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_voxel <= res;
			out_last  <= (out_pos_q == total_q - POS_W'(1));
		end
	end
endmodule
`default_nettype wire

// File: rtl/volume_weighted_blur_3d_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// volume_weighted_blur_3d_core: streaming weighted 3x3x3 volume blur
// Voxels enter in raster order on in_ch; blurred voxels leave on out_ch.
// Each output is a clamped weighted mean of center, face, edge and corner
// neighbors, taken only from voxels that lie on no face of the volume.
// Extents and weights are to be written on cfg_we/cfg_idx/cfg_data while idle,
// which the block does not enforce; a write to any extent restarts the stream.
// Outputs trail inputs by size_x*size_y + size_x + 1 voxels; once the
// volume is complete, drain requests (func = 1) flush the remaining tail.
// A request that makes no result passes only through the prep and decide
// states; one that makes a result also walks the 27 window taps (one ring
// read each), the weight multiply-accumulate and the bit-serial divider.
// One request is in flight at a time; the next is accepted as soon as the
// previous one is done, even if its result still sits in the output register.
// A stalled receiver holds the output register and blocks the next result.
// Reset clears positions, extents (64) and weights (256); the ring buffer
// needs no clearing, since only voxels already written are ever summed.
// ----------------------------------------------------------------------------
module volume_weighted_blur_3d_core #(
	parameter int MAX_X = vwb_pkg::DEF_MAX_X,
	parameter int MAX_Y = vwb_pkg::DEF_MAX_Y,
	parameter int MAX_Z = vwb_pkg::DEF_MAX_Z
) (
	input  logic                          clk,
	input  logic                          arst_n,
	vwb_in_if.sink                        in_ch,
	vwb_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [vwb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [vwb_pkg::CFG_W-1:0]     cfg_data
);
	import vwb_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;

	assign in_ch.ready = in_ready;

	// sequencer
	vwb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	vwb_dp #(
		.MAX_X (MAX_X),
		.MAX_Y (MAX_Y),
		.MAX_Z (MAX_Z)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_func   (in_ch.func),
		.in_voxel  (in_ch.voxel_in),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_voxel (out_ch.voxel_out),
		.out_last  (out_ch.last)
	);
endmodule
`default_nettype wire
